// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the breakpoint list rtl
// used by files that include it; expects i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define BPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPL_ASSERT(label, prop, msg)
`define BPL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/bpl_pkg.sv =====
// shared types and constants of the sorted breakpoint list
// no dependencies
package bpl_pkg;

    localparam int DEPTH        = 16;
    localparam int TIME_BITS    = 48;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);
    localparam int KIND_BITS    = 2;
    localparam int STATUS_BITS  = 4;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [TIME_BITS-1:0] FINAL_RESET = TIME_BITS'(1000000);

    // word kinds
    localparam logic [KIND_BITS-1:0] KIND_INSERT  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_POP     = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_RESTART = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOL   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FINAL = 1'b1;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 4'd0;
    localparam logic [STATUS_BITS-1:0] ST_REPLACED  = 4'd1;
    localparam logic [STATUS_BITS-1:0] ST_SKIP_NEAR = 4'd2;
    localparam logic [STATUS_BITS-1:0] ST_APPENDED  = 4'd3;
    localparam logic [STATUS_BITS-1:0] ST_SKIP_END  = 4'd4;
    localparam logic [STATUS_BITS-1:0] ST_POPPED    = 4'd5;
    localparam logic [STATUS_BITS-1:0] ST_RELOADED  = 4'd6;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 4'd7;
    localparam logic [STATUS_BITS-1:0] ST_RESTARTED = 4'd8;

    // list operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_NONE,
        OP_REPLACE,
        OP_INSERT,
        OP_APPEND,
        OP_POP,
        OP_RELOAD,
        OP_RESTART
    } t_op;

    // per cell control from the top level
    typedef struct packed {
        t_op  op;
        logic valid;        // cell holds a live entry
        logic at_end;       // cell is the first free slot
        logic is_last;      // cell holds the last live entry
        logic right_valid;  // right neighbor holds a live entry
        logic pos0;
        logic pos1;
    } t_cell_ctl;

    // search chain passed left to right
    typedef struct packed {
        logic any_gt;       // some earlier entry is later than the time
        logic near;         // left neighbor is within tolerance
    } t_link;

    // per cell result of the search
    typedef struct packed {
        logic first;        // first entry later than the time
        logic rep;          // first later entry within tolerance
        logic skn;          // entry before first later one within tolerance
        logic last_near;    // last entry within tolerance
    } t_cell_flag;

endpackage

// ===== rtl/core/bpl_if.sv =====
// valid/ready channel interfaces of the breakpoint list
// depends on bpl_pkg
interface bpl_cmd_if import bpl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  kind;
    logic [TIME_BITS-1:0]  event_time;

    modport source (output valid, kind, event_time, input ready);
    modport sink   (input valid, kind, event_time, output ready);
endinterface

interface bpl_res_if import bpl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [TIME_BITS-1:0]   head_time;
    logic [TIME_BITS-1:0]   next_time;
    logic [CNT_BITS-1:0]    entry_count;

    modport source (output valid, status, head_time, next_time, entry_count, input ready);
    modport sink   (input valid, status, head_time, next_time, entry_count, output ready);
endinterface

interface bpl_cfg_if import bpl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [TIME_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bpl_cell.sv =====
// one slot of the breakpoint chain: holds an entry, compares it, shifts
// depends on bpl_pkg
module bpl_cell import bpl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [TIME_BITS-1:0] i_time,
    input  logic [TIME_BITS-1:0] i_tol,
    input  logic [TIME_BITS-1:0] i_final,
    input  logic [TIME_BITS-1:0] i_left_entry,
    input  logic [TIME_BITS-1:0] i_right_entry,
    input  t_link                i_link,
    output t_link                o_link,
    output t_cell_flag           o_flag,
    output logic [TIME_BITS-1:0] o_entry
);

    logic [TIME_BITS-1:0] r_entry;
    logic [TIME_BITS-1:0] n_entry;
    logic                 r_gt;
    logic                 r_near;
    logic [TIME_BITS:0]   w_up;
    logic [TIME_BITS-1:0] w_dn;
    logic                 w_gt;
    logic                 w_near;
    logic                 w_first;

    // borrow of time - entry means the entry is later
    assign w_up   = {1'b0, i_time} - {1'b0, r_entry};
    assign w_dn   = r_entry - i_time;
    assign w_gt   = w_up[TIME_BITS];
    assign w_near = w_gt ? (w_dn <= i_tol) : (w_up[TIME_BITS-1:0] <= i_tol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gt   <= 1'b0;
            r_near <= 1'b0;
        end else begin
            r_gt   <= i_ctl.valid & w_gt;
            r_near <= w_near;
        end
    end

    assign w_first = r_gt & ~i_link.any_gt;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_REPLACE: begin
                if (w_first) n_entry = i_time;
            end
            OP_INSERT: begin
                if (w_first) begin
                    n_entry = i_time;
                end else if (i_link.any_gt && (i_ctl.valid || i_ctl.at_end)) begin
                    n_entry = i_left_entry;
                end
            end
            OP_APPEND: begin
                if (i_ctl.at_end) n_entry = i_time;
            end
            OP_POP: begin
                if (i_ctl.valid && i_ctl.right_valid) n_entry = i_right_entry;
            end
            OP_RELOAD: begin
                if (i_ctl.pos0) n_entry = i_right_entry;
                else if (i_ctl.pos1) n_entry = i_final;
            end
            OP_RESTART: begin
                if (i_ctl.pos0) n_entry = '0;
                else if (i_ctl.pos1) n_entry = i_final;
            end
            default: n_entry = r_entry;
        endcase
    end

    // only the two head slots have a defined value after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            if (i_ctl.pos0) r_entry <= '0;
            else if (i_ctl.pos1) r_entry <= FINAL_RESET;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_link.any_gt    = i_link.any_gt | r_gt;
    assign o_link.near      = r_near;
    assign o_flag.first     = w_first;
    assign o_flag.rep       = w_first & r_near;
    assign o_flag.skn       = w_first & i_link.near;
    assign o_flag.last_near = i_ctl.is_last & r_near;
    assign o_entry          = r_entry;

endmodule

// ===== rtl/core/sorted_breakpoint_list_core.sv =====
// top level of the sorted breakpoint list: control, config and the cell chain
// depends on bpl_pkg, bpl_if interfaces, bpl_cell and assert_macros.svh
//
// usage
// - i_cmd carries one word per operation: kind (insert, pop, restart) and
//   event_time, used by insert only
// - o_res returns exactly one word per command: status, the first two list
//   entries and the entry count after the operation
// - i_cfg writes merge_tolerance (index 0) and final_time (index 1); it is
//   always ready and should be written only while no command is in flight
// - after a command is accepted, every cell first compares its entry with the
//   time; then the chain resolves the first later entry and every cell shifts
//   or loads at once; then the result is registered and shown on o_res
// - i_cmd.ready is high only while the core is idle, so a new command is
//   taken only after the last one has finished its compare, update and
//   result steps
// - a waiting result does not block acceptance of the next command; that
//   command stalls only at its result step until o_res is free
// - synchronous active-low reset: list becomes {0, 1000000}, count 2,
//   tolerance 0, final_time 1000000, no result pending
`include "assert_macros.svh"
module sorted_breakpoint_list_core import bpl_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpl_cmd_if.sink       i_cmd,
    bpl_cfg_if.sink       i_cfg,
    bpl_res_if.source     o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [KIND_BITS-1:0]    r_kind;
    logic [TIME_BITS-1:0]    r_time;
    logic [CNT_BITS-1:0]     r_count;
    logic [CNT_BITS-1:0]     n_count;
    logic [STATUS_BITS-1:0]  r_status;
    logic [STATUS_BITS-1:0]  n_status;
    logic [TIME_BITS-1:0]    r_tol;
    logic [TIME_BITS-1:0]    r_final;
    logic                    r_out_valid;
    logic [STATUS_BITS-1:0]  r_out_status;
    logic [TIME_BITS-1:0]    r_out_head;
    logic [TIME_BITS-1:0]    r_out_next;
    logic [CNT_BITS-1:0]     r_out_count;

    t_op                     w_op;
    t_op                     w_cell_op;
    logic                    w_in_fire;
    logic                    w_out_free;
    logic                    w_full;
    logic                    w_any_gt;
    logic                    w_any_rep;
    logic                    w_any_skn;
    logic                    w_end_near;

    t_cell_ctl               w_ctl    [DEPTH];
    t_cell_flag              w_flag   [DEPTH];
    t_link                   w_link   [DEPTH+1];
    logic [TIME_BITS-1:0]    w_entry  [DEPTH];
    logic [DEPTH-1:0]        w_first;
    logic [DEPTH-1:0]        w_rep;
    logic [DEPTH-1:0]        w_skn;
    logic [DEPTH-1:0]        w_lnear;

    // handshakes
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_in_fire   = i_cmd.valid && (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_out_free  = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= '0;
            r_final <= FINAL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TOL:   r_tol   <= i_cfg.data;
                CFG_FINAL: r_final <= i_cfg.data;
                default:   r_tol   <= r_tol;
            endcase
        end
    end

    // the cell chain; the search flag ripples left to right through it
    assign w_link[0]  = '0;
    assign w_cell_op  = (r_state == S_UPD) ? w_op : OP_NONE;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [TIME_BITS-1:0] w_left;
        logic [TIME_BITS-1:0] w_right;

        assign w_ctl[k].op      = w_cell_op;
        assign w_ctl[k].valid   = CNT_BITS'(k) < r_count;
        assign w_ctl[k].at_end  = r_count == CNT_BITS'(k);
        assign w_ctl[k].is_last = r_count == CNT_BITS'(k + 1);
        assign w_ctl[k].pos0    = 1'(k == 0);
        assign w_ctl[k].pos1    = 1'(k == 1);

        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_entry[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign w_right              = '0;
            assign w_ctl[k].right_valid = 1'b0;
        end else begin : g_body
            assign w_right              = w_entry[k+1];
            assign w_ctl[k].right_valid = CNT_BITS'(k + 1) < r_count;
        end

        bpl_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl[k]),
            .i_time        (r_time),
            .i_tol         (r_tol),
            .i_final       (r_final),
            .i_left_entry  (w_left),
            .i_right_entry (w_right),
            .i_link        (w_link[k]),
            .o_link        (w_link[k+1]),
            .o_flag        (w_flag[k]),
            .o_entry       (w_entry[k])
        );

        assign w_first[k] = w_flag[k].first;
        assign w_rep[k]   = w_flag[k].rep;
        assign w_skn[k]   = w_flag[k].skn;
        assign w_lnear[k] = w_flag[k].last_near;
    end

    assign w_any_gt   = w_link[DEPTH].any_gt;
    assign w_any_rep  = |w_rep;
    assign w_any_skn  = |w_skn;
    assign w_end_near = |w_lnear;
    assign w_full     = r_count == CNT_BITS'(DEPTH);

    // decide the list operation from the chain result
    always_comb begin
        w_op     = OP_NONE;
        n_status = ST_FULL;
        n_count  = r_count;
        case (r_kind)
            KIND_INSERT: begin
                if (w_any_gt) begin
                    if (w_any_rep) begin
                        w_op     = OP_REPLACE;
                        n_status = ST_REPLACED;
                    end else if (w_any_skn) begin
                        n_status = ST_SKIP_NEAR;
                    end else if (!w_full) begin
                        w_op     = OP_INSERT;
                        n_status = ST_INSERTED;
                        n_count  = r_count + CNT_BITS'(1);
                    end
                end else if (w_end_near) begin
                    n_status = ST_SKIP_END;
                end else if (!w_full) begin
                    w_op     = OP_APPEND;
                    n_status = ST_APPENDED;
                    n_count  = r_count + CNT_BITS'(1);
                end
            end
            KIND_POP: begin
                if (r_count > CNT_BITS'(2)) begin
                    w_op     = OP_POP;
                    n_status = ST_POPPED;
                    n_count  = r_count - CNT_BITS'(1);
                end else begin
                    w_op     = OP_RELOAD;
                    n_status = ST_RELOADED;
                end
            end
            KIND_RESTART: begin
                w_op     = OP_RESTART;
                n_status = ST_RESTARTED;
                n_count  = CNT_BITS'(2);
            end
            default: begin
                w_op     = OP_NONE;
                n_status = ST_FULL;
            end
        endcase
    end

    // sequencer with the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_BITS'(2);
            r_out_valid <= 1'b0;
        end else begin
            // in S_OUT the result step itself decides the valid flag
            if (r_out_valid && o_res.ready && (r_state != S_OUT)) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_kind  <= i_cmd.kind;
                        r_time  <= i_cmd.event_time;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_count  <= n_count;
                    r_status <= n_status;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_head   <= w_entry[0];
                        r_out_next   <= w_entry[1];
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.head_time   = r_out_head;
    assign o_res.next_time   = r_out_next;
    assign o_res.entry_count = r_out_count;

    `BPL_ASSERT(a_count_range, (r_count >= CNT_BITS'(2)) && (r_count <= CNT_BITS'(DEPTH)), "entry count out of range")
    `BPL_ASSERT(a_one_first, $onehot0(w_first), "more than one first later entry")
    `BPL_ASSERT_NEXT(a_accept_cmp, w_in_fire, r_state == S_CMP, "accepted word did not start compare")
    `BPL_ASSERT_NEXT(a_insert_grows, (r_state == S_UPD) && ((w_op == OP_INSERT) || (w_op == OP_APPEND)), r_count == $past(r_count) + CNT_BITS'(1), "insert did not grow the list")
    `BPL_ASSERT_NEXT(a_out_after_upd, (r_state == S_OUT) && w_out_free, r_out_valid && (r_out_count == r_count), "result not loaded")

endmodule

// ===== sim/sorted_breakpoint_list_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for sorted_breakpoint_list_core: directed and random
// command words checked against an in-bench model of the breakpoint list
// depends on bpl_pkg, the bpl_if interfaces and the core rtl
module sorted_breakpoint_list_core_tb;
    import bpl_pkg::*;

    // the one kind code the package leaves unnamed; the core must ignore it
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;

    // one result word as the core should return it
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [TIME_BITS-1:0]   head;
        logic [TIME_BITS-1:0]   second;
        logic [CNT_BITS-1:0]    count;
    } bp_word_t;

    logic i_clk;
    logic i_rst_n;

    bpl_cmd_if cmd_bus ();
    bpl_cfg_if cfg_bus ();
    bpl_res_if res_bus ();

    sorted_breakpoint_list_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    // shadow of the breakpoint list and of the two registers
    logic [TIME_BITS-1:0] bp_list [DEPTH];
    int                   bp_count;
    logic [TIME_BITS-1:0] bp_tol;
    logic [TIME_BITS-1:0] bp_fin;

    // results still owed by the core, oldest first
    bp_word_t pending_q [$];

    // when set, both sides insert random gaps before each word
    bit stall_on;
    int fail_count;
    int cmd_count;
    int res_count;
    int setting_count;
    int res_hold;
    bit status_seen [9];

    // clock, 2 ns period
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // global watchdog
    initial begin
        #400000;
        $display("sorted_breakpoint_list_core_tb NOT OK");
        $finish;
    end

    // -------------------------------------------------------------------
    // list model: applies one command word, returns the expected result
    // -------------------------------------------------------------------
    function automatic bp_word_t list_update(logic [KIND_BITS-1:0] kind,
                                             logic [TIME_BITS-1:0] t);
        bp_word_t               w;
        logic [STATUS_BITS-1:0] st;
        int                     first_later;
        first_later = -1;
        case (kind)
            KIND_INSERT: begin
                // search for the first entry strictly later than t
                for (int i = 0; i < bp_count; i++) begin
                    if (first_later < 0 && bp_list[i] > t) first_later = i;
                end
                if (first_later >= 0) begin
                    if (bp_list[first_later] - t <= bp_tol) begin
                        bp_list[first_later] = t;
                        st = ST_REPLACED;
                    end else if (first_later > 0 &&
                                 t - bp_list[first_later-1] <= bp_tol) begin
                        st = ST_SKIP_NEAR;
                    end else if (bp_count >= DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        for (int j = bp_count; j > first_later; j--)
                            bp_list[j] = bp_list[j-1];
                        bp_list[first_later] = t;
                        bp_count++;
                        st = ST_INSERTED;
                    end
                end else if (t - bp_list[bp_count-1] <= bp_tol) begin
                    // nothing later: t is at or past the tail
                    st = ST_SKIP_END;
                end else if (bp_count >= DEPTH) begin
                    st = ST_FULL;
                end else begin
                    bp_list[bp_count] = t;
                    bp_count++;
                    st = ST_APPENDED;
                end
            end
            KIND_POP: begin
                if (bp_count > 2) begin
                    for (int j = 1; j < bp_count; j++) bp_list[j-1] = bp_list[j];
                    bp_count--;
                    st = ST_POPPED;
                end else begin
                    // two entries left: shift and reload the end time
                    bp_list[0] = bp_list[1];
                    bp_list[1] = bp_fin;
                    st = ST_RELOADED;
                end
            end
            KIND_RESTART: begin
                bp_list[0] = '0;
                bp_list[1] = bp_fin;
                bp_count   = 2;
                st = ST_RESTARTED;
            end
            default: st = ST_FULL;
        endcase
        w.status = st;
        w.head   = bp_list[0];
        w.second = bp_list[1];
        w.count  = CNT_BITS'(bp_count);
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // time close to one of the live entries, within about twice the tolerance
    function automatic logic [TIME_BITS-1:0] time_near_entry();
        logic [63:0] base;
        logic [63:0] span;
        logic [63:0] delta;
        logic [63:0] t64;
        base  = {16'd0, bp_list[$urandom_range(0, bp_count - 1)]};
        span  = {16'd0, bp_tol} * 64'd2 + 64'd3;
        delta = rand64() % span;
        if ($urandom_range(0, 1) && base >= delta) t64 = base - delta;
        else t64 = base + delta;
        if (t64 > TIME_MAX) t64 = TIME_MAX;
        return t64[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] pick_time();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return TIME_BITS'(rand64());
        if (sel == 1) return $urandom_range(0, 1) ? TIME_MAX[TIME_BITS-1:0] : '0;
        if (sel <= 6) return time_near_entry();
        return TIME_BITS'(rand64() % ({16'd0, bp_fin} + 64'd1));
    endfunction

    // -------------------------------------------------------------------
    // channel tasks
    // -------------------------------------------------------------------
    // sends one command word; valid stays high on return so that a word
    // with no gap follows back to back
    task automatic send_word(logic [KIND_BITS-1:0] kind, logic [TIME_BITS-1:0] t);
        int gap;
        gap = stall_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.kind       <= kind;
        cmd_bus.event_time <= t;
        do @(posedge i_clk); while (!cmd_bus.ready);
        pending_q.push_back(list_update(kind, t));
        cmd_count++;
    endtask

    // stops sending and waits until every owed result has come back
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // register write; only called with the core drained
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [TIME_BITS-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (idx == CFG_TOL) bp_tol = val;
        else bp_fin = val;
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [TIME_BITS-1:0] tol, logic [TIME_BITS-1:0] fin);
        wait_drained();
        write_reg(CFG_TOL, tol);
        write_reg(CFG_FINAL, fin);
        setting_count++;
    endtask

    task automatic cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // result side: check each accepted word, then maybe hold ready low
    always begin
        @(posedge i_clk);
        if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (pending_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result word, expected none, got status %0d",
                         $time, res_bus.status);
            end else begin
                bp_word_t w;
                w = pending_q.pop_front();
                cmp_field("status", w.status, res_bus.status);
                cmp_field("head_time", w.head, res_bus.head_time);
                cmp_field("next_time", w.second, res_bus.next_time);
                cmp_field("entry_count", w.count, res_bus.entry_count);
                if (w.status <= ST_RESTARTED) status_seen[w.status] = 1'b1;
                res_count++;
            end
            res_hold = stall_on ? $urandom_range(0, 17) : 0;
            if (res_hold > 0) begin
                res_bus.ready <= 1'b0;
                repeat (res_hold) @(posedge i_clk);
                res_bus.ready <= 1'b1;
            end
        end
    end

    // -------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------
    // every kind, time extremes, pop from two entries leaving the list
    // out of order, skip at the tail and skip next to the head
    task automatic test_list_basics();
        set_regs('0, FINAL_RESET);
        send_word(KIND_INSERT, TIME_MAX[TIME_BITS-1:0]);   // append past the end
        send_word(KIND_INSERT, 48'd500);                   // insert in the middle
        send_word(KIND_POP, '0);
        send_word(KIND_POP, '0);
        send_word(KIND_POP, '0);      // two left: reload gives {max, final}
        send_word(KIND_UNUSED, TIME_MAX[TIME_BITS-1:0]);
        send_word(KIND_RESTART, '0);
        send_word(KIND_INSERT, '0);                        // equal to the head
        send_word(KIND_INSERT, FINAL_RESET);               // equal to the tail
    endtask

    // fill to capacity, then replace, skip and an insert that is dropped
    task automatic test_full_list();
        set_regs(48'd1, FINAL_RESET);
        send_word(KIND_RESTART, '0);
        for (int k = 1; k <= DEPTH - 2; k++) send_word(KIND_INSERT, TIME_BITS'(10 * k));
        send_word(KIND_INSERT, 48'd9);      // replaces 10 while full
        send_word(KIND_INSERT, 48'd21);     // skipped, close to 20
        send_word(KIND_INSERT, 48'd500);    // no room
    endtask

    // random traffic under one register setting
    task automatic random_phase(logic [TIME_BITS-1:0] tol, logic [TIME_BITS-1:0] fin,
                                int n, bit stalls);
        int r;
        set_regs(tol, fin);
        stall_on = stalls;
        for (int k = 0; k < n; k++) begin
            // every so often let the core run dry before going on
            if (k % 40 == 39) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 68) send_word(KIND_INSERT, pick_time());
            else if (r < 88) send_word(KIND_POP, TIME_BITS'(rand64()));
            else if (r < 95) send_word(KIND_RESTART, TIME_BITS'(rand64()));
            else send_word(KIND_UNUSED, TIME_BITS'(rand64()));
        end
        stall_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        random_phase('0, FINAL_RESET, 90, 1'b1);
        random_phase(48'd1000, FINAL_RESET, 90, 1'b0);
        random_phase(TIME_MAX[TIME_BITS-1:0], TIME_MAX[TIME_BITS-1:0], 60, 1'b1);
        random_phase(TIME_BITS'($urandom_range(1, 5000)), TIME_BITS'(rand64()), 90, 1'b1);
        // end time of zero: reloads put zero behind a later head
        random_phase(48'd50, '0, 60, 1'b1);
        random_phase(TIME_BITS'(rand64()), TIME_BITS'(rand64()), 60, 1'b1);
    endtask

    // -------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------
    initial begin
        int kinds_hit;
        i_rst_n            <= 1'b0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.kind       <= KIND_INSERT;
        cmd_bus.event_time <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_TOL;
        cfg_bus.data       <= '0;
        res_bus.ready      <= 1'b1;
        stall_on      = 1'b1;
        fail_count    = 0;
        cmd_count     = 0;
        res_count     = 0;
        setting_count = 0;
        kinds_hit     = 0;
        // model state after reset
        foreach (bp_list[i]) bp_list[i] = '0;
        bp_list[1] = FINAL_RESET;
        bp_count   = 2;
        bp_tol     = '0;
        bp_fin     = FINAL_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_list_basics();
        test_full_list();
        test_random_traffic();

        // let any stray word show up before the verdict
        wait_drained();
        repeat (12) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            fail_count++;
            $display("%0t: results missing, expected %0d more, got 0",
                     $time, pending_q.size());
        end
        foreach (status_seen[i]) if (status_seen[i]) kinds_hit++;
        $display("ran %0d commands over %0d register settings, %0d results checked",
                 cmd_count, setting_count, res_count);
        $display("%0d of 9 status codes observed, %0d mismatches", kinds_hit, fail_count);
        if (fail_count == 0) begin
            $display("sorted_breakpoint_list_core_tb OK");
        end else begin
            $display("sorted_breakpoint_list_core_tb NOT OK");
        end
        $finish;
    end

endmodule
